// ----- rtl/bdtp_pkg.sv -----
// shared types, constants and helpers of the balancing drive controller
`default_nettype none
package bdtp_pkg;

  localparam int ERR_W   = 16;
  localparam int TIME_W  = 16;
  localparam int GAIN_W  = 20;
  localparam int GAINS_W = 3 * GAIN_W;
  localparam int VOLT_W  = 16;
  localparam int LIM_W   = 15;
  localparam int INV_W   = 2;
  localparam int CFG_W   = GAINS_W;
  localparam int CFG_IDX_W = 3;

  // product widths of the state-free terms
  localparam int PD_W  = GAIN_W + ERR_W;        // kp*e and kd*e_rate
  localparam int EDT_W = ERR_W + TIME_W + 1;    // e*dt, signed by unsigned
  localparam int INC_W = EDT_W - 4;             // increment after floor to Q.24

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BALANCE_GAINS  = 3'd0,
    CFG_POSITION_GAINS = 3'd1,
    CFG_HEADING_GAINS  = 3'd2,
    CFG_VOLTAGE_LIMIT  = 3'd3,
    CFG_WHEEL_INVERT   = 3'd4,
    CFG_FALL_LIMIT     = 3'd5,
    CFG_STEP_TIME_LIM  = 3'd6
  } cfg_idx_t;

  localparam logic [GAINS_W-1:0] BALANCE_GAINS_RST  = 60'd140791175450368;
  localparam logic [GAINS_W-1:0] POSITION_GAINS_RST = '0;
  localparam logic [GAINS_W-1:0] HEADING_GAINS_RST  = '0;
  localparam logic [LIM_W-1:0]   VOLTAGE_LIMIT_RST  = 15'd12288;
  localparam logic [INV_W-1:0]   WHEEL_INVERT_RST   = '0;
  localparam logic [LIM_W-1:0]   FALL_LIMIT_RST     = 15'd6144;
  localparam logic [TIME_W-1:0]  STEP_TIME_LIM_RST  = 16'd32768;

  // per-lane stage control from the top level and the merge stage
  typedef struct packed {
    logic load;   // new request enters the product stage
    logic step;   // product stage moves on to the output register
    logic clear;  // fallen request: integral back to zero
    logic grow;   // anti-windup allows integration
  } lane_ctl_t;

  // width of one loop sum in Q.20 for a given integral width
  function automatic int loop_width(input int iw);
    int t;
    begin
      t = (iw + 9 > PD_W) ? iw + 9 : PD_W;
      return t + 2;
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/bdtp_if.sv -----
// request and result channel interfaces of the balancing drive controller
`default_nettype none
interface bdtp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] position_error;
  logic signed [15:0] velocity_error;
  logic signed [15:0] tilt_error;
  logic signed [15:0] tilt_rate_error;
  logic signed [15:0] heading_error;
  logic signed [15:0] heading_rate_error;
  logic        [15:0] elapsed_time;

  modport source (output valid, position_error, velocity_error, tilt_error,
                  tilt_rate_error, heading_error, heading_rate_error, elapsed_time,
                  input ready);
  modport sink   (input valid, position_error, velocity_error, tilt_error,
                  tilt_rate_error, heading_error, heading_rate_error, elapsed_time,
                  output ready);
endinterface

interface bdtp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_voltage;
  logic signed [15:0] right_voltage;
  logic               fallen;

  modport source (output valid, left_voltage, right_voltage, fallen, input ready);
  modport sink   (input valid, left_voltage, right_voltage, fallen, output ready);
endinterface
`default_nettype wire

// ----- rtl/bdtp_lane.sv -----
// one pid loop lane: product stage, integral term and saturating integrator
`default_nettype none
module bdtp_lane
  import bdtp_pkg::*;
#(
  parameter int INTEGRAL_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire lane_ctl_t                ctl,
  input  wire logic [GAINS_W-1:0]       gains,
  input  wire logic signed [ERR_W-1:0]  err,
  input  wire logic signed [ERR_W-1:0]  err_rate,
  input  wire logic [TIME_W-1:0]        dt,
  output logic signed [loop_width(INTEGRAL_WIDTH)-1:0] u
);

  localparam int IW = INTEGRAL_WIDTH;
  localparam int UW = loop_width(INTEGRAL_WIDTH);
  localparam int HW = IW + 8;                      // ki * integral high part
  localparam int LW = GAIN_W + 13;                 // ki * integral low 12 bits
  localparam int SW = ((IW > INC_W) ? IW : INC_W) + 1;

  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic signed [PD_W-1:0]   p_r, d_r;
  logic signed [INC_W-1:0]  inc_r;
  logic signed [EDT_W-1:0]  edt;
  logic signed [IW-1:0]     integ_r, integ_nxt, integ_sat;
  logic signed [HW-1:0]     hi_p;
  logic signed [LW-1:0]     lo_p;
  logic signed [SW-1:0]     integ_sum;
  logic                     sat_ok;

  assign kp = $signed(gains[GAIN_W-1:0]);
  assign ki = $signed(gains[2*GAIN_W-1:GAIN_W]);
  assign kd = $signed(gains[3*GAIN_W-1:2*GAIN_W]);

  assign edt = EDT_W'(err) * $signed({1'b0, dt});

  // state-free products, one multiply level
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      p_r   <= PD_W'(kp) * PD_W'(err);
      d_r   <= PD_W'(kd) * PD_W'(err_rate);
      inc_r <= edt[EDT_W-1:4];
    end
  end

  // integral term floored to q.20, split at bit 12
  assign hi_p = HW'(ki) * HW'($signed(integ_r[IW-1:12]));
  assign lo_p = LW'(ki) * $signed({1'b0, integ_r[11:0]});

  assign u = UW'(p_r) + UW'(hi_p) + UW'($signed(lo_p[LW-1:12])) + UW'(d_r);

  // saturating integrator
  assign integ_sum = SW'(integ_r) + SW'(inc_r);
  assign sat_ok    = (&integ_sum[SW-1:IW-1]) || !(|integ_sum[SW-1:IW-1]);
  assign integ_sat = sat_ok ? integ_sum[IW-1:0]
                   : (integ_sum[SW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}});

  always_comb begin
    integ_nxt = integ_r;
    if (ctl.step) begin
      if (ctl.clear) begin
        integ_nxt = '0;
      end else if (ctl.grow) begin
        integ_nxt = integ_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else begin
      integ_r <= integ_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bdtp_merge.sv -----
// merge stage: wheel mixing, inversion, clamping and anti-windup decision
`default_nettype none
module bdtp_merge
  import bdtp_pkg::*;
#(
  parameter int LOOP_W = 43
) (
  input  wire logic signed [LOOP_W-1:0] ub,
  input  wire logic signed [LOOP_W-1:0] up,
  input  wire logic signed [LOOP_W-1:0] uy,
  input  wire logic [LIM_W-1:0]         voltage_limit,
  input  wire logic [INV_W-1:0]         wheel_invert,
  input  wire logic                     fallen,
  output logic signed [VOLT_W-1:0]      left_voltage,
  output logic signed [VOLT_W-1:0]      right_voltage,
  output logic                          grow
);

  localparam int WW = LOOP_W + 3;

  logic signed [WW-1:0]     vr, vl, vr_i, vl_i, lim, nlim;
  logic signed [VOLT_W-1:0] pos_v, neg_v, wl, wr;
  logic                     in_l, in_r;

  assign vr   = WW'(ub) + WW'(up) + WW'(uy);
  assign vl   = WW'(ub) + WW'(up) - WW'(uy);
  assign vl_i = wheel_invert[0] ? -vl : vl;
  assign vr_i = wheel_invert[1] ? -vr : vr;

  assign lim  = WW'($signed({1'b0, voltage_limit, 10'b0}));
  assign nlim = -lim;

  assign in_l = (vl_i < lim) && (vl_i > nlim);
  assign in_r = (vr_i < lim) && (vr_i > nlim);
  assign grow = in_l && in_r;

  assign pos_v = $signed({1'b0, voltage_limit});
  assign neg_v = -pos_v;

  always_comb begin
    if (vl_i > lim) begin
      wl = pos_v;
    end else if (vl_i < nlim) begin
      wl = neg_v;
    end else begin
      wl = vl_i[VOLT_W+9:10];
    end
    if (vr_i > lim) begin
      wr = pos_v;
    end else if (vr_i < nlim) begin
      wr = neg_v;
    end else begin
      wr = vr_i[VOLT_W+9:10];
    end
  end

  assign left_voltage  = fallen ? '0 : wl;
  assign right_voltage = fallen ? '0 : wr;

endmodule
`default_nettype wire

// ----- rtl/balancing_drive_triple_pid.sv -----
// top level of the three-loop balancing drive pid controller
`default_nettype none
// Takes one request per clock cycle unless the result channel stalls, and
// returns its wheel voltages through a product stage and an output register. The
// balance, position and heading loops run as three parallel lanes; each lane
// forms kp*e, kd*e_rate and the integral increment e*dt in the product stage.
// The second stage forms ki*integral, mixes the wheels, clamps them and
// updates the integrals in the same cycle, so the integral loop (integral
// register, ki multiply, wheel sum, limit compare, integral register) sets
// the clock period. A request with zero elapsed time or one above
// step_time_limit is taken and dropped without a result or any state change.
// A request whose tilt error magnitude exceeds fall_limit returns zero
// voltages with fallen set and clears all integrals. The request channel keeps
// moving while a result waits, as long as the product stage is free.
module balancing_drive_triple_pid
  import bdtp_pkg::*;
#(
  parameter int INTEGRAL_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  bdtp_in_if.sink                in_ch,
  bdtp_out_if.source             out_ch,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam int UW = loop_width(INTEGRAL_WIDTH);

  // configuration registers
  logic [GAINS_W-1:0] bal_gains_r, pos_gains_r, hdg_gains_r;
  logic [LIM_W-1:0]   volt_lim_r, fall_lim_r;
  logic [INV_W-1:0]   invert_r;
  logic [TIME_W-1:0]  time_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bal_gains_r <= BALANCE_GAINS_RST;
      pos_gains_r <= POSITION_GAINS_RST;
      hdg_gains_r <= HEADING_GAINS_RST;
      volt_lim_r  <= VOLTAGE_LIMIT_RST;
      invert_r    <= WHEEL_INVERT_RST;
      fall_lim_r  <= FALL_LIMIT_RST;
      time_lim_r  <= STEP_TIME_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BALANCE_GAINS:  bal_gains_r <= cfg_wdata[GAINS_W-1:0];
        CFG_POSITION_GAINS: pos_gains_r <= cfg_wdata[GAINS_W-1:0];
        CFG_HEADING_GAINS:  hdg_gains_r <= cfg_wdata[GAINS_W-1:0];
        CFG_VOLTAGE_LIMIT:  volt_lim_r  <= cfg_wdata[LIM_W-1:0];
        CFG_WHEEL_INVERT:   invert_r    <= cfg_wdata[INV_W-1:0];
        CFG_FALL_LIMIT:     fall_lim_r  <= cfg_wdata[LIM_W-1:0];
        CFG_STEP_TIME_LIM:  time_lim_r  <= cfg_wdata[TIME_W-1:0];
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  // pipeline control
  logic a_valid_r, a_valid_nxt, a_fallen_r;
  logic out_valid_r, out_valid_nxt;
  logic adv, step, in_acc, time_ok, fallen_in;
  logic [ERR_W:0] tilt_abs;
  logic signed [ERR_W:0] tilt_x;
  lane_ctl_t lane_ctl;
  logic grow;

  assign adv    = !out_valid_r || out_ch.ready;   // output register free next edge
  assign step   = a_valid_r && adv;
  assign in_ch.ready = !a_valid_r || adv;
  assign in_acc = in_ch.valid && in_ch.ready;

  // bad time drops the request here
  assign time_ok = (in_ch.elapsed_time != '0) && (in_ch.elapsed_time <= time_lim_r);

  // tilt magnitude, most negative code counts as fallen
  assign tilt_x    = (ERR_W+1)'(in_ch.tilt_error);
  assign tilt_abs  = tilt_x[ERR_W] ? $unsigned(-tilt_x) : $unsigned(tilt_x);
  assign fallen_in = tilt_abs > {2'b00, fall_lim_r};

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_acc) begin
      a_valid_nxt = time_ok;
    end else if (step) begin
      a_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_fallen_r <= fallen_in;
    end
  end

  assign lane_ctl.load  = in_acc;
  assign lane_ctl.step  = step;
  assign lane_ctl.clear = a_fallen_r;
  assign lane_ctl.grow  = grow;

  // three loop lanes
  logic signed [UW-1:0] ub, up, uy;

  bdtp_lane #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_lane_bal (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (lane_ctl),
    .gains    (bal_gains_r),
    .err      (in_ch.tilt_error),
    .err_rate (in_ch.tilt_rate_error),
    .dt       (in_ch.elapsed_time),
    .u        (ub)
  );

  bdtp_lane #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_lane_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (lane_ctl),
    .gains    (pos_gains_r),
    .err      (in_ch.position_error),
    .err_rate (in_ch.velocity_error),
    .dt       (in_ch.elapsed_time),
    .u        (up)
  );

  bdtp_lane #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_lane_hdg (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (lane_ctl),
    .gains    (hdg_gains_r),
    .err      (in_ch.heading_error),
    .err_rate (in_ch.heading_rate_error),
    .dt       (in_ch.elapsed_time),
    .u        (uy)
  );

  // wheel mixing and clamp
  logic signed [VOLT_W-1:0] left_v, right_v;

  bdtp_merge #(.LOOP_W(UW)) u_merge (
    .ub            (ub),
    .up            (up),
    .uy            (uy),
    .voltage_limit (volt_lim_r),
    .wheel_invert  (invert_r),
    .fallen        (a_fallen_r),
    .left_voltage  (left_v),
    .right_voltage (right_v),
    .grow          (grow)
  );

  // output register
  logic signed [VOLT_W-1:0] left_r, right_r;
  logic                     fallen_r;

  always_ff @(posedge clk) begin
    if (step) begin
      left_r   <= left_v;
      right_r  <= right_v;
      fallen_r <= a_fallen_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.left_voltage  = left_r;
  assign out_ch.right_voltage = right_r;
  assign out_ch.fallen        = fallen_r;

  // a fallen result carries zero voltages
  a_fallen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fallen_r |-> (left_r == '0) && (right_r == '0))
    else $error("fallen result with nonzero voltage");

  // a request with zero elapsed time never reaches the product stage
  a_bad_time_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.elapsed_time == '0) |=> !a_valid_r)
    else $error("zero-time request kept");

  // a waiting request in the product stage is not lost while the output stalls
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !adv |=> a_valid_r)
    else $error("product stage dropped a request");

  // a request leaving the product stage shows up as a result
  a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("stepped request produced no result");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// testbench of the three-loop balancing drive pid: random requests checked against a predictor
module testbench;
  import bdtp_pkg::*;

  localparam int          INTEG_W         = 32;
  localparam int          PERIOD          = 20;
  localparam int          RESET_CYCLES    = 7;
  localparam int          RANDOM_PHASES   = 9;
  localparam int          ITEMS_PER_PHASE = 150;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          HOLD_CYCLES     = 240;
  localparam int unsigned CYCLE_LIMIT     = 250000;

  // one request: six errors and the elapsed time
  typedef struct {
    logic signed [ERR_W-1:0] position;
    logic signed [ERR_W-1:0] velocity;
    logic signed [ERR_W-1:0] tilt;
    logic signed [ERR_W-1:0] tilt_rate;
    logic signed [ERR_W-1:0] heading;
    logic signed [ERR_W-1:0] heading_rate;
    logic [TIME_W-1:0]       dt;
  } drive_req_t;

  // one result: the two wheel voltages and the fall flag
  typedef struct {
    logic signed [VOLT_W-1:0] left;
    logic signed [VOLT_W-1:0] right;
    logic                     fallen;
  } wheel_cmd_t;

  // the whole register file
  typedef struct {
    logic [GAINS_W-1:0] balance;
    logic [GAINS_W-1:0] position;
    logic [GAINS_W-1:0] heading;
    logic [LIM_W-1:0]   volt_limit;
    logic [INV_W-1:0]   invert;
    logic [LIM_W-1:0]   fall_limit;
    logic [TIME_W-1:0]  step_limit;
  } drive_setting_t;

  // predicts wheel commands from accepted requests and checks the results against them
  class drive_scoreboard;
    logic [GAINS_W-1:0] loop_gains [3];   // balance, position, heading
    logic [LIM_W-1:0]   volt_limit;
    logic [LIM_W-1:0]   fall_limit;
    logic [INV_W-1:0]   invert;
    logic [TIME_W-1:0]  step_limit;
    longint             integ [3];        // tilt, position and heading integrals, Q.24
    wheel_cmd_t         expected_cmds [$];
    int                 mismatches;
    int                 requests;
    int                 dropped;
    int                 results;
    int                 falls_seen;

    function new();
      loop_gains[0] = BALANCE_GAINS_RST;
      loop_gains[1] = POSITION_GAINS_RST;
      loop_gains[2] = HEADING_GAINS_RST;
      volt_limit    = VOLTAGE_LIMIT_RST;
      invert        = WHEEL_INVERT_RST;
      fall_limit    = FALL_LIMIT_RST;
      step_limit    = STEP_TIME_LIM_RST;
      foreach (integ[k]) integ[k] = 0;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    function void set_register(cfg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_BALANCE_GAINS:  loop_gains[0] = data[GAINS_W-1:0];
        CFG_POSITION_GAINS: loop_gains[1] = data[GAINS_W-1:0];
        CFG_HEADING_GAINS:  loop_gains[2] = data[GAINS_W-1:0];
        CFG_VOLTAGE_LIMIT:  volt_limit    = data[LIM_W-1:0];
        CFG_WHEEL_INVERT:   invert        = data[INV_W-1:0];
        CFG_FALL_LIMIT:     fall_limit    = data[LIM_W-1:0];
        CFG_STEP_TIME_LIM:  step_limit    = data[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    // kp*e + ki*integral + kd*e_rate in Q.20, integral term floored from Q.32
    function longint loop_drive(int k, longint e, longint e_rate);
      longint kp, ki, kd;
      kp = longint'($signed(loop_gains[k][19:0]));
      ki = longint'($signed(loop_gains[k][39:20]));
      kd = longint'($signed(loop_gains[k][59:40]));
      return kp * e + ((ki * integ[k]) >>> 12) + kd * e_rate;
    endfunction

    function longint saturate(longint v);
      longint hi;
      hi = (longint'(1) <<< (INTEG_W - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function logic signed [VOLT_W-1:0] wheel_volts(longint v, longint lim);
      longint r;
      if (v > lim) r = longint'(volt_limit);
      else if (v < -lim) r = -longint'(volt_limit);
      else r = v >>> 10;
      return VOLT_W'(r);
    endfunction

    function void note_request(drive_req_t q);
      longint     th, dt, ub, up, uy, vl, vr, lim;
      wheel_cmd_t c;
      requests++;
      if (q.dt == 0 || q.dt > step_limit) begin
        dropped++;
        return;
      end
      th = q.tilt;
      dt = longint'(q.dt);
      if ((th < 0 ? -th : th) > longint'(fall_limit)) begin
        foreach (integ[k]) integ[k] = 0;
        c.left   = '0;
        c.right  = '0;
        c.fallen = 1'b1;
        expected_cmds.push_back(c);
        return;
      end
      ub = loop_drive(0, th, q.tilt_rate);
      up = loop_drive(1, q.position, q.velocity);
      uy = loop_drive(2, q.heading, q.heading_rate);
      vr = ub + up + uy;
      vl = ub + up - uy;
      if (invert[0]) vl = -vl;
      if (invert[1]) vr = -vr;
      lim = longint'(volt_limit) <<< 10;
      if ((vl < 0 ? -vl : vl) < lim && (vr < 0 ? -vr : vr) < lim) begin
        integ[0] = saturate(integ[0] + ((th * dt) >>> 4));
        integ[1] = saturate(integ[1] + ((longint'(q.position) * dt) >>> 4));
        integ[2] = saturate(integ[2] + ((longint'(q.heading) * dt) >>> 4));
      end
      c.left   = wheel_volts(vl, lim);
      c.right  = wheel_volts(vr, lim);
      c.fallen = 1'b0;
      expected_cmds.push_back(c);
    endfunction

    task check_result(wheel_cmd_t got);
      wheel_cmd_t want;
      results++;
      if (got.fallen === 1'b1) falls_seen++;
      if (expected_cmds.size() == 0) begin
        report($sformatf("result %0d/%0d/%0d with no request waiting",
                         got.left, got.right, got.fallen));
        return;
      end
      want = expected_cmds.pop_front();
      if (got.left !== want.left)
        report($sformatf("left voltage %0d, expected %0d", got.left, want.left));
      if (got.right !== want.right)
        report($sformatf("right voltage %0d, expected %0d", got.right, want.right));
      if (got.fallen !== want.fallen)
        report($sformatf("fallen %0b, expected %0b", got.fallen, want.fallen));
    endtask

    function int outstanding();
      return expected_cmds.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_idx_t             cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  bit                   steady = 1'b0;       // both sides drop their idling
  int                   hold_tickets = 0;    // bumped to ask the receiver for a long hold-off
  int unsigned          cycle_count = 0;

  bdtp_in_if  in_ch ();
  bdtp_out_if out_ch ();

  drive_scoreboard sb = new();

  balancing_drive_triple_pid #(
    .INTEGRAL_WIDTH(INTEG_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(PERIOD / 2) clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, sb.outstanding());
      $display("Test completed with failures");
      $finish;
    end
  end

  // monitor: sample both handshakes at the edge, results first so the queue order holds
  always @(posedge clk) begin
    wheel_cmd_t got;
    drive_req_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.left   = out_ch.left_voltage;
        got.right  = out_ch.right_voltage;
        got.fallen = out_ch.fallen;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.position     = in_ch.position_error;
        seen.velocity     = in_ch.velocity_error;
        seen.tilt         = in_ch.tilt_error;
        seen.tilt_rate    = in_ch.tilt_rate_error;
        seen.heading      = in_ch.heading_error;
        seen.heading_rate = in_ch.heading_rate_error;
        seen.dt           = in_ch.elapsed_time;
        sb.note_request(seen);
      end
    end
  end

  // result side: random stalls, a steady stretch, and long hold-offs on request
  initial begin : receiver
    int stall_left;
    int holds_served;
    stall_left   = 0;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (holds_served != hold_tickets) begin
        // hold off long enough for the pipeline to fill and block new requests
        holds_served = hold_tickets;
        stall_left   = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 27);
      end
    end
  end

  // offer one request, idling first at random, and return at the edge that takes it
  task automatic send_request(drive_req_t q);
    while (!steady && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.position_error     <= q.position;
    in_ch.velocity_error     <= q.velocity;
    in_ch.tilt_error         <= q.tilt;
    in_ch.tilt_rate_error    <= q.tilt_rate;
    in_ch.heading_error      <= q.heading;
    in_ch.heading_rate_error <= q.heading_rate;
    in_ch.elapsed_time       <= q.dt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // register write; the predictor follows at once since nothing is in flight
  task automatic write_register(cfg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.set_register(idx, data);
    @(posedge clk);
  endtask

  task automatic apply_setting(drive_setting_t s);
    write_register(CFG_BALANCE_GAINS, s.balance);
    write_register(CFG_POSITION_GAINS, s.position);
    write_register(CFG_HEADING_GAINS, s.heading);
    write_register(CFG_VOLTAGE_LIMIT, CFG_W'(s.volt_limit));
    write_register(CFG_WHEEL_INVERT, CFG_W'(s.invert));
    write_register(CFG_FALL_LIMIT, CFG_W'(s.fall_limit));
    write_register(CFG_STEP_TIME_LIM, CFG_W'(s.step_limit));
    cfg_we <= 1'b0;
  endtask

  // stop offering, wait for every result, then let a dropped request clear the pipeline
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic drive_req_t make_req(int p, int v, int t, int tr, int h, int hr,
                                          int unsigned dt);
    drive_req_t q;
    q.position     = ERR_W'(p);
    q.velocity     = ERR_W'(v);
    q.tilt         = ERR_W'(t);
    q.tilt_rate    = ERR_W'(tr);
    q.heading      = ERR_W'(h);
    q.heading_rate = ERR_W'(hr);
    q.dt           = TIME_W'(dt);
    return q;
  endfunction

  // mostly modest gains so the loops stay out of the clamp, some zero, some full range
  function automatic logic [GAIN_W-1:0] rand_gain();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return GAIN_W'($urandom());
    return GAIN_W'(int'($urandom_range(8192)) - 4096);
  endfunction

  function automatic logic [GAINS_W-1:0] rand_gains();
    return {rand_gain(), rand_gain(), rand_gain()};
  endfunction

  function automatic logic signed [ERR_W-1:0] rand_error();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return ERR_W'(int'($urandom_range(4096)) - 2048);
    if (pick < 80) return ERR_W'($urandom());
    return ERR_W'(int'($urandom_range(16384)) - 8192);
  endfunction

  // tilt mostly inside the fall limit and time mostly valid, so the integrals get to work
  function automatic drive_req_t random_request();
    drive_req_t  q;
    int          fl;
    int unsigned sl;
    int unsigned pick;
    fl = int'(sb.fall_limit);
    sl = sb.step_limit;
    q.position     = rand_error();
    q.velocity     = rand_error();
    q.tilt_rate    = rand_error();
    q.heading      = rand_error();
    q.heading_rate = rand_error();
    if ($urandom_range(99) < 82) q.tilt = ERR_W'(int'($urandom_range(2 * fl)) - fl);
    else q.tilt = ERR_W'($urandom());
    pick = $urandom_range(99);
    if (pick < 5) q.dt = '0;
    else if (pick < 10 && sl < 65535) q.dt = TIME_W'($urandom_range(65535, sl + 1));
    else q.dt = TIME_W'($urandom_range(sl, 1));
    return q;
  endfunction

  function automatic drive_setting_t default_setting();
    drive_setting_t s;
    s.balance    = BALANCE_GAINS_RST;
    s.position   = POSITION_GAINS_RST;
    s.heading    = HEADING_GAINS_RST;
    s.volt_limit = VOLTAGE_LIMIT_RST;
    s.invert     = WHEEL_INVERT_RST;
    s.fall_limit = FALL_LIMIT_RST;
    s.step_limit = STEP_TIME_LIM_RST;
    return s;
  endfunction

  function automatic drive_setting_t phase_setting(int ph);
    drive_setting_t s;
    s.balance    = rand_gains();
    s.position   = rand_gains();
    s.heading    = rand_gains();
    s.volt_limit = LIM_W'($urandom_range(32767));
    s.invert     = INV_W'($urandom_range(3));
    s.fall_limit = LIM_W'($urandom_range(32767));
    s.step_limit = TIME_W'($urandom_range(65535, 1));
    case (ph)
      0: begin
        // zero gains never clamp, so the integrals run into saturation
        s.balance    = '0;
        s.position   = '0;
        s.heading    = '0;
        s.volt_limit = '1;
        s.fall_limit = '1;
        s.step_limit = '1;
      end
      2: begin
        // every register at its top value
        s.balance    = '1;
        s.position   = '1;
        s.heading    = '1;
        s.volt_limit = '1;
        s.invert     = '1;
        s.fall_limit = '1;
        s.step_limit = '1;
      end
      3: begin
        // largest and most negative gains, tiny limit, only zero tilt and a dt of one pass
        s.balance    = {20'h80000, 20'h7FFFF, 20'h80000};
        s.position   = {20'h7FFFF, 20'h80000, 20'h7FFFF};
        s.volt_limit = LIM_W'(1);
        s.invert     = INV_W'(1);
        s.fall_limit = '0;
        s.step_limit = TIME_W'(1);
      end
      default: ;
    endcase
    return s;
  endfunction

  initial begin : stimulus
    drive_setting_t s;
    drive_req_t     q;
    int             counted;
    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_index                <= CFG_BALANCE_GAINS;
    cfg_wdata                <= '0;
    in_ch.valid              <= 1'b0;
    in_ch.position_error     <= '0;
    in_ch.velocity_error     <= '0;
    in_ch.tilt_error         <= '0;
    in_ch.tilt_rate_error    <= '0;
    in_ch.heading_error      <= '0;
    in_ch.heading_rate_error <= '0;
    in_ch.elapsed_time       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests under the reset configuration
    send_request(make_req(0, 0, 0, 0, 0, 0, 1));
    send_request(make_req(0, 0, 'h100, 0, 0, 0, 'h1000));          // unclamped, integral grows
    send_request(make_req(0, 0, 'h100, -'h80, 0, 0, 'h1000));      // integral term now in play
    send_request(make_req(0, 0, 6144, 0, 0, 0, 32768));            // tilt at the limit, dt at its cap
    send_request(make_req(0, 0, 6145, 0, 0, 0, 100));              // just past the fall limit
    send_request(make_req(0, 0, -6145, 0, 0, 0, 100));
    send_request(make_req(0, 0, -32768, 0, 0, 0, 100));            // most negative tilt always falls
    send_request(make_req(0, 0, 10, 0, 0, 0, 0));                  // zero time: dropped
    send_request(make_req(0, 0, 10, 0, 0, 0, 32769));              // time over the cap: dropped
    send_request(make_req(0, 0, 10, 0, 0, 0, 65535));
    send_request(make_req(32767, -32768, 0, 32767, -32768, 32767, 1));
    send_request(make_req(-32768, -32768, -6144, -32768, -32768, -32768, 32768));
    send_request(make_req(32767, 32767, 100, -100, 32767, 32767, 1));
    send_request(make_req(0, 0, -200, 0, 0, 0, 2000));
    settle();

    // step time limit of zero drops every request
    s = default_setting();
    s.step_limit = '0;
    apply_setting(s);
    send_request(make_req(0, 0, 5, 0, 0, 0, 1));
    send_request(make_req(0, 0, 5, 0, 0, 0, 65535));
    send_request(make_req(0, 0, 5, 0, 0, 0, 0));
    settle();

    // zero voltage limit: outputs pinned to zero, integrals frozen
    s = default_setting();
    s.balance    = rand_gains();
    s.position   = rand_gains();
    s.heading    = rand_gains();
    s.volt_limit = '0;
    s.invert     = '1;
    s.fall_limit = '1;
    s.step_limit = '1;
    apply_setting(s);
    send_request(make_req(1000, -500, 300, 20, -700, 40, 5000));
    send_request(make_req(-32768, 32767, 0, 0, 32767, -32768, 65535));
    send_request(make_req(0, 0, 0, 0, 0, 0, 1));
    settle();

    // each wheel inverted on its own, with a heading term splitting the wheels
    s = default_setting();
    s.heading = {20'd0, 20'd0, 20'h00100};
    s.invert  = INV_W'(1);
    apply_setting(s);
    send_request(make_req(0, 0, 'h80, 0, 'h400, 0, 'h800));
    send_request(make_req(0, 0, -'h80, 0, -'h400, 0, 'h800));
    settle();
    s.invert = INV_W'(2);
    apply_setting(s);
    send_request(make_req(0, 0, 'h80, 0, 'h400, 0, 'h800));
    send_request(make_req(0, 0, -'h80, 0, -'h400, 0, 'h800));
    settle();

    // random phases, each with its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_setting(phase_setting(ph));
      steady <= (ph == 4);
      if (ph == 1 || ph == 6) hold_tickets <= hold_tickets + 1;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        q = random_request();
        if (q.dt != 0 && q.dt <= sb.step_limit) counted++;
        send_request(q);
      end
      settle();
    end

    $display("%0d requests sent, %0d dropped for bad time, %0d results checked (%0d fallen)",
             sb.requests, sb.dropped, sb.results, sb.falls_seen);
    $display("%0d register settings, incl. zero and full-scale limits and both wheel inversions",
             RANDOM_PHASES + 5);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
